[sv/two_level_sector_allocator_top_assert.svh]
// Assertion macros shared by the sector allocator RTL.
// No dependencies; included by files that carry assertions.
`ifndef TWO_LEVEL_SECTOR_ALLOCATOR_TOP_ASSERT_SVH
`define TWO_LEVEL_SECTOR_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TLSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TLSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tlsa_pkg.sv]
// Shared types, codes and helpers for the two-level sector allocator.
// No dependencies.
`default_nettype none

package tlsa_pkg;

  localparam int SECTOR_W  = 19;
  localparam int FLAG_COLS = 64;
  // divide phases: quotient, then remainder
  localparam int DIV_STEPS = 2;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic    lat_in;
    logic    div_step;
    logic    div_start_w;
    logic    div_take_w;
    logic    row_rd_scan;
    logic    row_rd_grp;
    logic    row_latch;
    logic    scan_eval;
    logic    bm_rd;
    logic    bm_wr_clr;
    logic    bm_wr_set;
    logic    bm_wr_open;
    logic    word_clr;
    logic    word_inc;
    logic    set_used;
    logic    clr_used;
    logic    set_full;
    logic    clr_full;
    logic    row_wr;
    logic    sect1;
    logic    sect2;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic oob;
    logic rd_col_used;
    logic partial_any;
    logic unused_any;
    logic last_row;
    logic last_word;
    logic word_free;
    logic word_full_after;
    logic word_full;
    logic word_nonzero;
    logic out_busy;
  } stat_t;

  // index of the lowest set bit, 0 when none
  function automatic logic [5:0] lowest_bit(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/tlsa_in_if.sv]
// Request channel: valid/ready plus request payload.
// Depends on tlsa_pkg for the sector width.
`default_nettype none

interface tlsa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tlsa_pkg::SECTOR_W-1:0] sector_index;

  modport source (output valid, kind, sector_index, input ready);
  modport sink   (input valid, kind, sector_index, output ready);
endinterface

`default_nettype wire

[sv/tlsa_out_if.sv]
// Result channel: valid/ready plus result payload.
// Depends on tlsa_pkg for the sector width.
`default_nettype none

interface tlsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlsa_pkg::SECTOR_W-1:0] allocated_sector;
  logic [1:0]                    status;

  modport source (output valid, allocated_sector, status, input ready);
  modport sink   (input valid, allocated_sector, status, output ready);
endinterface

`default_nettype wire

[sv/two_level_sector_allocator_top.sv]
// Two-level sector allocator, one request at a time, one result beat each.
// Allocate: scan flag rows for a partly used group, then its words for a free bit;
// else open the first unused group, writing its bitmap words; else no space.
// Free: clear the bit, check the group's words; ignored if out of range or unused.
// Next request taken the cycle after result load; load waits only on a pending beat.
// Synchronous active-low reset; flag rows invalidated at once, bitmap not cleared.
`default_nettype none

module two_level_sector_allocator_top #(
  parameter int GROUP_COUNT       = 1024,
  parameter int SECTORS_PER_GROUP = 512,
  parameter int WORD_BITS         = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  tlsa_in_if.sink    in_ch,
  tlsa_out_if.source out_ch
);

  tlsa_pkg::cmd_t  cmd;
  tlsa_pkg::stat_t stat;

  tlsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlsa_dpath #(
    .GROUP_COUNT       (GROUP_COUNT),
    .SECTORS_PER_GROUP (SECTORS_PER_GROUP),
    .WORD_BITS         (WORD_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_sector_index      (in_ch.sector_index),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_allocated_sector (out_ch.allocated_sector),
    .out_status           (out_ch.status)
  );

endmodule

`default_nettype wire

[sv/tlsa_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module tlsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/tlsa_ctrl.sv]
// Sequencer of the sector allocator: issues datapath commands per request.
// Depends on tlsa_pkg and the assertion header.
`default_nettype none
`include "two_level_sector_allocator_top_assert.svh"

module tlsa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_kind,
  output logic                 in_ready,
  input  wire tlsa_pkg::stat_t stat,
  output tlsa_pkg::cmd_t       cmd
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_DIV_G  = 20'h00002,
    S_DIV_W  = 20'h00004,
    S_F_ROW  = 20'h00008,
    S_F_BIT  = 20'h00010,
    S_CLR_RD = 20'h00020,
    S_CLR_CK = 20'h00040,
    S_A_RD   = 20'h00080,
    S_A_CK   = 20'h00100,
    S_O_RD   = 20'h00200,
    S_O_ROW  = 20'h00400,
    S_O_WR   = 20'h00800,
    S_P_RD   = 20'h01000,
    S_P_CK   = 20'h02000,
    S_Q_RD   = 20'h04000,
    S_Q_CK   = 20'h08000,
    S_SECT1  = 20'h10000,
    S_SECT2  = 20'h20000,
    S_WB     = 20'h40000,
    S_OUT    = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.status_code = tlsa_pkg::ST_DONE;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.lat_in = 1'b1;
          state_nxt = (in_kind == tlsa_pkg::KIND_FREE) ? S_DIV_G : S_A_RD;
        end
      end
      S_DIV_G: begin
        if (!stat.div_done) cmd.div_step = 1'b1;
        else begin
          cmd.div_start_w = 1'b1;
          state_nxt = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (!stat.div_done) cmd.div_step = 1'b1;
        else begin
          cmd.div_take_w = 1'b1;
          cmd.row_rd_grp = 1'b1;
          if (stat.oob) begin
            cmd.set_status = 1'b1;
            cmd.status_code = tlsa_pkg::ST_IGNORED;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_F_ROW;
          end
        end
      end
      S_F_ROW: begin
        cmd.row_latch = 1'b1;
        if (!stat.rd_col_used) begin
          cmd.set_status = 1'b1;
          cmd.status_code = tlsa_pkg::ST_IGNORED;
          state_nxt = S_OUT;
        end else begin
          cmd.bm_rd = 1'b1;
          state_nxt = S_F_BIT;
        end
      end
      S_F_BIT: begin
        cmd.bm_wr_clr = 1'b1;
        cmd.clr_full = 1'b1;
        cmd.word_clr = 1'b1;
        state_nxt = S_CLR_RD;
      end
      S_CLR_RD: begin
        cmd.bm_rd = 1'b1;
        state_nxt = S_CLR_CK;
      end
      S_CLR_CK: begin
        if (stat.word_nonzero || stat.last_word) begin
          cmd.clr_used = !stat.word_nonzero;
          cmd.set_status = 1'b1;
          cmd.status_code = tlsa_pkg::ST_DONE;
          state_nxt = S_WB;
        end else begin
          cmd.word_inc = 1'b1;
          state_nxt = S_CLR_RD;
        end
      end
      S_A_RD: begin
        cmd.row_rd_scan = 1'b1;
        state_nxt = S_A_CK;
      end
      S_A_CK: begin
        cmd.scan_eval = 1'b1;
        if (stat.partial_any) begin
          cmd.word_clr = 1'b1;
          state_nxt = S_P_RD;
        end else if (stat.last_row) begin
          if (stat.unused_any) state_nxt = S_O_RD;
          else begin
            cmd.set_status = 1'b1;
            cmd.status_code = tlsa_pkg::ST_NOSPACE;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_O_RD: begin
        cmd.row_rd_grp = 1'b1;
        state_nxt = S_O_ROW;
      end
      S_O_ROW: begin
        cmd.row_latch = 1'b1;
        cmd.word_clr = 1'b1;
        state_nxt = S_O_WR;
      end
      S_O_WR: begin
        cmd.bm_wr_open = 1'b1;
        cmd.set_used = 1'b1;
        cmd.clr_full = 1'b1;
        if (stat.last_word) begin
          cmd.set_status = 1'b1;
          cmd.status_code = tlsa_pkg::ST_DONE;
          state_nxt = S_SECT1;
        end else begin
          cmd.word_inc = 1'b1;
        end
      end
      S_P_RD: begin
        cmd.bm_rd = 1'b1;
        state_nxt = S_P_CK;
      end
      S_P_CK: begin
        if (stat.word_free) begin
          cmd.bm_wr_set = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_code = tlsa_pkg::ST_DONE;
          if (!stat.word_full_after) state_nxt = S_SECT1;
          else if (stat.last_word) begin
            cmd.set_full = 1'b1;
            state_nxt = S_SECT1;
          end else begin
            cmd.word_inc = 1'b1;
            state_nxt = S_Q_RD;
          end
        end else if (stat.last_word) begin
          cmd.set_full = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_code = tlsa_pkg::ST_NOSPACE;
          state_nxt = S_WB;
        end else begin
          cmd.word_inc = 1'b1;
          state_nxt = S_P_RD;
        end
      end
      S_Q_RD: begin
        cmd.bm_rd = 1'b1;
        state_nxt = S_Q_CK;
      end
      S_Q_CK: begin
        if (!stat.word_full) state_nxt = S_SECT1;
        else if (stat.last_word) begin
          cmd.set_full = 1'b1;
          state_nxt = S_SECT1;
        end else begin
          cmd.word_inc = 1'b1;
          state_nxt = S_Q_RD;
        end
      end
      S_SECT1: begin
        cmd.sect1 = 1'b1;
        state_nxt = S_SECT2;
      end
      S_SECT2: begin
        cmd.sect2 = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.row_wr = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `TLSA_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE, "accepted beat did not start work")

endmodule

`default_nettype wire

[sv/tlsa_dpath.sv]
// Datapath: flag row RAM, bitmap RAM, reciprocal divider, result register.
// Depends on tlsa_pkg, tlsa_ram and the assertion header.
`default_nettype none
`include "two_level_sector_allocator_top_assert.svh"

module tlsa_dpath #(
  parameter int GROUP_COUNT       = 1024,
  parameter int SECTORS_PER_GROUP = 512,
  parameter int WORD_BITS         = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [tlsa_pkg::SECTOR_W-1:0] in_sector_index,
  input  wire tlsa_pkg::cmd_t                cmd,
  output tlsa_pkg::stat_t                    stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tlsa_pkg::SECTOR_W-1:0]      out_allocated_sector,
  output logic [1:0]                         out_status
);

  localparam int SW    = tlsa_pkg::SECTOR_W;
  localparam int COLS  = tlsa_pkg::FLAG_COLS;
  localparam int WPG   = (SECTORS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
  localparam int ROWS  = (GROUP_COUNT + COLS - 1) / COLS;
  localparam int GW    = $clog2(GROUP_COUNT);
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WW    = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int BM_DEPTH = GROUP_COUNT * WPG;
  localparam int BM_AW = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int LAST_BITS = SECTORS_PER_GROUP - (WPG - 1) * WORD_BITS;
  localparam int MW    = SW + 1;
  localparam int PW    = 2 * SW + 2;
  localparam int K1    = SW + $clog2(SECTORS_PER_GROUP);
  localparam int K2    = SW + $clog2(WORD_BITS);
  localparam logic [MW-1:0] M1 = MW'(((64'd1 << K1) + 64'(SECTORS_PER_GROUP) - 64'd1)
                                     / 64'(SECTORS_PER_GROUP));
  localparam logic [MW-1:0] M2 = MW'(((64'd1 << K2) + 64'(WORD_BITS) - 64'd1)
                                     / 64'(WORD_BITS));

  // divider
  logic [SW-1:0] dvd_r, quo_r, rem_r, quo_nxt, rem_nxt;
  logic [MW-1:0] mul_k;
  logic [PW-1:0] prod;
  logic          div_sel_r;
  logic [1:0]    cnt_r;
  logic          oob_r;

  // request state
  logic [GW-1:0]     group_r, unused_r;
  logic              have_unused_r;
  logic [ROW_W-1:0]  row_idx_r;
  logic [2*COLS-1:0] row_r;
  logic [WW-1:0]     word_r, hitw_r;
  logic [BW-1:0]     bit_r;
  logic [SW-1:0]     sect_r;
  tlsa_pkg::status_t status_r;

  // result register
  logic          out_valid_r;
  logic [SW-1:0] out_sector_r;
  logic [1:0]    out_status_r;

  // flag rows
  logic [ROWS-1:0]   row_valid_r;
  logic              rd_vld_r;
  logic [ROW_W-1:0]  f_raddr, row_of_grp;
  logic [5:0]        col;
  logic [2*COLS-1:0] f_rdata, rowdat;
  logic [COLS-1:0]   exist, partial_v, unused_v;
  logic [5:0]        pcol, ucol;
  logic [GW-1:0]     pgrp, ugrp;

  // bitmap
  logic [BM_AW-1:0]     bm_addr;
  logic [WORD_BITS-1:0] bm_rdata, bm_wdata, wmask, last_mask, free_v, lb_hot, bit_hot;
  logic [5:0]           lb;
  logic                 bm_we;

  assign row_of_grp = ROW_W'(group_r >> 6);
  assign col        = 6'(group_r);
  assign f_raddr    = cmd.row_rd_scan ? row_idx_r : row_of_grp;
  assign rowdat     = rd_vld_r ? f_rdata : '0;

  always_comb begin
    for (int i = 0; i < COLS; i++) begin
      exist[i] = (32'(row_idx_r) * COLS + i) < GROUP_COUNT;
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      last_mask[i] = (i < LAST_BITS);
    end
  end

  assign partial_v = rowdat[COLS-1:0] & ~rowdat[2*COLS-1:COLS] & exist;
  assign unused_v  = ~rowdat[COLS-1:0] & exist;
  assign pcol      = tlsa_pkg::lowest_bit(64'(partial_v));
  assign ucol      = tlsa_pkg::lowest_bit(64'(unused_v));
  assign pgrp      = GW'(32'(row_idx_r) * COLS + 32'(pcol));
  assign ugrp      = GW'(32'(row_idx_r) * COLS + 32'(ucol));

  assign bm_addr = BM_AW'(32'(group_r) * WPG + 32'(word_r));
  assign wmask   = (32'(word_r) == WPG - 1) ? last_mask : '1;
  assign free_v  = ~bm_rdata & wmask;
  assign lb      = tlsa_pkg::lowest_bit(64'(free_v));
  assign lb_hot  = WORD_BITS'(1) << BW'(lb);
  assign bit_hot = WORD_BITS'(1) << bit_r;
  assign bm_we   = cmd.bm_wr_clr | cmd.bm_wr_set | cmd.bm_wr_open;

  always_comb begin
    bm_wdata = bm_rdata & ~bit_hot;
    if (cmd.bm_wr_set)  bm_wdata = bm_rdata | lb_hot;
    if (cmd.bm_wr_open) bm_wdata = (word_r == '0) ? WORD_BITS'(1) : '0;
  end

  // quotient by reciprocal multiply, remainder by multiply-subtract next cycle
  assign mul_k   = div_sel_r ? M2 : M1;
  assign prod    = PW'(dvd_r) * PW'(mul_k);
  assign quo_nxt = div_sel_r ? SW'(prod >> K2) : SW'(prod >> K1);
  assign rem_nxt = dvd_r - SW'(32'(quo_r) * (div_sel_r ? WORD_BITS : SECTORS_PER_GROUP));

  tlsa_ram #(.WIDTH(2 * COLS), .DEPTH(ROWS)) u_flag_ram (
    .clk   (clk),
    .we    (cmd.row_wr),
    .waddr (row_of_grp),
    .wdata (row_r),
    .re    (cmd.row_rd_scan | cmd.row_rd_grp),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  tlsa_ram #(.WIDTH(WORD_BITS), .DEPTH(BM_DEPTH)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_addr),
    .wdata (bm_wdata),
    .re    (cmd.bm_rd),
    .raddr (bm_addr),
    .rdata (bm_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (cmd.row_rd_scan || cmd.row_rd_grp) rd_vld_r <= row_valid_r[f_raddr];
      if (cmd.row_wr) row_valid_r[row_of_grp] <= 1'b1;
      if (cmd.lat_in || cmd.div_start_w) cnt_r <= 2'(tlsa_pkg::DIV_STEPS);
      else if (cmd.div_step) cnt_r <= cnt_r - 2'd1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_in) begin
      dvd_r         <= in_sector_index;
      div_sel_r     <= 1'b0;
      row_idx_r     <= '0;
      have_unused_r <= 1'b0;
      sect_r        <= '0;
      hitw_r        <= '0;
      bit_r         <= '0;
      word_r        <= '0;
    end
    if (cmd.div_step) begin
      if (cnt_r == 2'd2) quo_r <= quo_nxt;
      else               rem_r <= rem_nxt;
    end
    if (cmd.div_start_w) begin
      oob_r     <= (32'(quo_r) >= GROUP_COUNT);
      group_r   <= GW'(quo_r);
      dvd_r     <= rem_r;
      div_sel_r <= 1'b1;
    end
    if (cmd.div_take_w) begin
      word_r <= WW'(quo_r);
      bit_r  <= BW'(rem_r);
    end
    if (cmd.row_latch) row_r <= rowdat;
    if (cmd.scan_eval) begin
      row_r     <= rowdat;
      row_idx_r <= row_idx_r + ROW_W'(1);
      if (|partial_v) group_r <= pgrp;
      else if (have_unused_r) group_r <= unused_r;
      else group_r <= ugrp;
      if (!have_unused_r && (|unused_v)) begin
        unused_r      <= ugrp;
        have_unused_r <= 1'b1;
      end
    end
    if (cmd.bm_wr_set) begin
      bit_r  <= BW'(lb);
      hitw_r <= word_r;
    end
    if (cmd.word_clr) word_r <= '0;
    else if (cmd.word_inc) word_r <= word_r + WW'(1);
    if (cmd.set_used) row_r[col] <= 1'b1;
    if (cmd.clr_used) row_r[col] <= 1'b0;
    if (cmd.set_full) row_r[COLS + 32'(col)] <= 1'b1;
    if (cmd.clr_full) row_r[COLS + 32'(col)] <= 1'b0;
    if (cmd.sect1) sect_r <= SW'(32'(group_r) * SECTORS_PER_GROUP);
    if (cmd.sect2) sect_r <= sect_r + SW'(32'(hitw_r) * WORD_BITS) + SW'(bit_r);
    if (cmd.set_status) status_r <= cmd.status_code;
    if (cmd.out_load) begin
      out_sector_r <= sect_r;
      out_status_r <= status_r;
    end
  end

  always_comb begin
    stat                 = '0;
    stat.div_done        = (cnt_r == '0);
    stat.oob             = oob_r;
    stat.rd_col_used     = rowdat[col];
    stat.partial_any     = |partial_v;
    stat.unused_any      = (|unused_v) | have_unused_r;
    stat.last_row        = (32'(row_idx_r) == ROWS - 1);
    stat.last_word       = (32'(word_r) == WPG - 1);
    stat.word_free       = |free_v;
    stat.word_full_after = ((bm_rdata | lb_hot) & wmask) == wmask;
    stat.word_full       = (bm_rdata & wmask) == wmask;
    stat.word_nonzero    = |(bm_rdata & wmask);
    stat.out_busy        = out_valid_r & ~out_ready;
  end

  assign out_valid            = out_valid_r;
  assign out_allocated_sector = out_sector_r;
  assign out_status           = out_status_r;

  `TLSA_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready, "result register overwritten")
  `TLSA_ASSERT_IMP(a_div_step_count, clk, rst_n, cmd.div_step, cnt_r != '0, "divider stepped past end")
  `TLSA_ASSERT_NXT(a_row_valid_set, clk, rst_n, cmd.row_wr, row_valid_r[$past(row_of_grp)], "written row not marked valid")

endmodule

`default_nettype wire

[tb/sv/tlsa_tb_pkg.sv]
// Scoreboard for the two-level sector allocator testbench: a behavioral
// allocator that predicts each result beat and checks the ones observed.
// Depends on tlsa_pkg for the status codes, request kinds and sector width.
`default_nettype none

package tlsa_tb_pkg;
  import tlsa_pkg::*;

  localparam int NGROUP = 1024;
  localparam int SPG    = 512;
  localparam int WPG    = 8;

  typedef struct {
    logic [SECTOR_W-1:0] sector;
    status_t             status;
  } alloc_result_t;

  class sector_scoreboard;
    bit            used_q[NGROUP];
    bit            full_q[NGROUP];
    logic [63:0]   bitmap_q[NGROUP][WPG];
    alloc_result_t pending_q[$];
    int            errors;

    function void clear_state();
      foreach (used_q[g]) begin
        used_q[g] = 0;
        full_q[g] = 0;
        for (int w = 0; w < WPG; w++) bitmap_q[g][w] = '0;
      end
      pending_q.delete();
      errors = 0;
    endfunction

    function bit group_full(int g);
      for (int w = 0; w < WPG; w++) if (bitmap_q[g][w] != '1) return 0;
      return 1;
    endfunction

    function bit group_empty(int g);
      for (int w = 0; w < WPG; w++) if (bitmap_q[g][w] != '0) return 0;
      return 1;
    endfunction

    function alloc_result_t allocate();
      alloc_result_t r;
      int part, unused;
      part = -1;
      unused = -1;
      r.sector = '0;
      r.status = ST_DONE;
      for (int g = 0; g < NGROUP; g++) begin
        if (used_q[g] && !full_q[g]) begin
          part = g;
          break;
        end
        if (!used_q[g] && unused < 0) unused = g;
      end
      if (part < 0) begin
        if (unused < 0) begin
          r.status = ST_NOSPACE;
          return r;
        end
        for (int w = 0; w < WPG; w++) bitmap_q[unused][w] = '0;
        bitmap_q[unused][0] = 64'd1;
        used_q[unused] = 1;
        full_q[unused] = 0;
        r.sector = SECTOR_W'(unused * SPG);
        return r;
      end
      for (int w = 0; w < WPG; w++) begin
        for (int b = 0; b < 64; b++) begin
          if (!bitmap_q[part][w][b]) begin
            bitmap_q[part][w][b] = 1'b1;
            if (group_full(part)) full_q[part] = 1;
            r.sector = SECTOR_W'(part * SPG + w * 64 + b);
            return r;
          end
        end
      end
      full_q[part] = 1;
      r.status = ST_NOSPACE;
      return r;
    endfunction

    function void note_request(logic kind, logic [SECTOR_W-1:0] idx);
      alloc_result_t r;
      int g, s;
      if (kind == KIND_ALLOC) begin
        r = allocate();
      end else begin
        g = int'(idx) / SPG;
        s = int'(idx) % SPG;
        r.sector = '0;
        r.status = ST_DONE;
        if (g >= NGROUP || !used_q[g]) begin
          r.status = ST_IGNORED;
        end else begin
          bitmap_q[g][s / 64][s % 64] = 1'b0;
          full_q[g] = 0;
          if (group_empty(g)) used_q[g] = 0;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [SECTOR_W-1:0] sector, logic [1:0] status);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: sector %0d status %0d", sector, status);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (sector !== e.sector) begin
        $error("allocated_sector: expected %0d, got %0d", e.sector, sector);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass
endpackage

`default_nettype wire

[tb/sv/two_level_sector_allocator_top_tb.sv]
// Top-level testbench for two_level_sector_allocator_top: directed and random
// allocate/free traffic with random stalls, checked by the scoreboard class.
// Depends on tlsa_pkg, tlsa_tb_pkg and the two channel interfaces.
`default_nettype none

module two_level_sector_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlsa_pkg::*;
  import tlsa_tb_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   sending_done = 0;
  bit   hold_off = 0;
  int   idle_cycles = 0;
  logic [SECTOR_W-1:0] live_q[$];

  sector_scoreboard sb = new();

  tlsa_in_if  in_ch();
  tlsa_out_if out_ch();

  two_level_sector_allocator_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ALLOC;
    in_ch.sector_index = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send(logic kind, logic [SECTOR_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.sector_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(kind, idx);
    if (kind == KIND_ALLOC) begin
      if (sb.pending_q[$].status == ST_DONE) live_q.push_back(sb.pending_q[$].sector);
    end else begin
      foreach (live_q[i]) if (live_q[i] == idx) begin
        live_q.delete(i);
        break;
      end
    end
  endtask

  task automatic free_random_live();
    int k;
    logic [SECTOR_W-1:0] s;
    if (live_q.size() == 0) begin
      send(KIND_ALLOC, SECTOR_W'($urandom));
      return;
    end
    k = $urandom_range(0, live_q.size() - 1);
    s = live_q[k];
    send(KIND_FREE, s);
  endtask

  // receiver side
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.allocated_sector, out_ch.status);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    sb.clear_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: frees into nothing, opening groups, edge indexes
    send(KIND_FREE, '0);
    send(KIND_FREE, '1);
    send(KIND_FREE, SECTOR_W'(NGROUP * SPG - 1));
    send(KIND_ALLOC, '1);
    send(KIND_ALLOC, '0);
    send(KIND_ALLOC, '0);
    send(KIND_FREE, SECTOR_W'(1));
    send(KIND_FREE, SECTOR_W'(1));
    send(KIND_FREE, SECTOR_W'(SPG - 1));
    send(KIND_FREE, '0);
    send(KIND_FREE, SECTOR_W'(2));
    send(KIND_FREE, SECTOR_W'(2));
    send(KIND_ALLOC, '0);
    // fill group 0 completely, then free one sector of a full group
    repeat (SPG) send(KIND_ALLOC, SECTOR_W'($urandom));
    send(KIND_FREE, SECTOR_W'(100));
    send(KIND_ALLOC, '0);
    // long receiver stall while requests keep coming
    hold_off = 1;
    repeat (12) send(KIND_ALLOC, SECTOR_W'($urandom));
    for (int n = 0; n < 110; n++) begin
      r = $urandom_range(0, 9);
      if (r < 5) send(KIND_ALLOC, SECTOR_W'($urandom));
      else if (r < 9) free_random_live();
      else send(KIND_FREE, SECTOR_W'($urandom));
    end
    in_ch.valid <= 1'b0;
    sending_done = 1;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/tlsa_pkg.sv
sv/tlsa_in_if.sv
sv/tlsa_out_if.sv
sv/tlsa_ram.sv
sv/tlsa_ctrl.sv
sv/tlsa_dpath.sv
sv/two_level_sector_allocator_top.sv
tb/sv/tlsa_tb_pkg.sv
tb/sv/two_level_sector_allocator_top_tb.sv
